// ----- rtl/glob_pattern_matcher_unit_macros.svh -----
// Assertion macros shared by the glob pattern matcher RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef GLOB_PATTERN_MATCHER_UNIT_MACROS_SVH
`define GLOB_PATTERN_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gpm_pkg.sv -----
// Package for the glob pattern matcher: payload types, command struct,
// function codes and special pattern characters. Depends on nothing.
package gpm_pkg;

    // Default pattern capacity in bytes.
    localparam int MAX_PATTERN_DEF = 32;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    // Function codes of an input transaction.
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_FEED   = 2'd2;
    localparam logic [1:0] FUNC_END    = 2'd3;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] ch;
    } gpm_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } gpm_out_t;

    // Decoded command, already qualified by the stage advancing.
    typedef struct packed {
        logic clear;
        logic append;
        logic feed;
        logic finish;
    } gpm_cmd_t;

endpackage

// ----- rtl/gpm_pattern_store.sv -----
// Pattern byte store with length and overflow tracking; produces per-position
// star and match masks for the current subject byte. Depends on gpm_pkg.
module gpm_pattern_store
    import gpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  gpm_cmd_t               cmd,
    input  logic [7:0]             ch,
    output logic [LEN_W-1:0]       len,
    output logic                   overflow,
    output logic [MAX_PATTERN-1:0] star_mask,
    output logic [MAX_PATTERN-1:0] hit_mask
);

    localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]       chars_reg [MAX_PATTERN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             has_room;

    assign has_room = (len_reg < LEN_W'(MAX_PATTERN));

    // Length and overflow bookkeeping.
    always_comb
    begin
        len_next      = len_reg;
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            len_next      = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.append)
        begin
            if (has_room)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            overflow_reg <= overflow_next;
        end
    end

    // Pattern bytes are written at the fill position and need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.append && has_room)
        begin
            chars_reg[len_reg[ADDR_W-1:0]] <= ch;
        end
    end

    // Every stored position compares against the subject byte in parallel.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            logic in_range;
            logic is_star;
            in_range     = (LEN_W'(i) < len_reg);
            is_star      = (chars_reg[i] == STAR_CHAR);
            star_mask[i] = in_range && is_star;
            hit_mask[i]  = in_range && !is_star
                           && ((chars_reg[i] == ANY_CHAR) || (chars_reg[i] == ch));
        end
    end

    assign len      = len_reg;
    assign overflow = overflow_reg;

endmodule

// ----- rtl/gpm_live_set.sv -----
// Set of live pattern positions: star closure by a log-depth prefix network,
// then the per-byte step. Depends on gpm_pkg and the assertion macros.
`include "glob_pattern_matcher_unit_macros.svh"

module gpm_live_set
    import gpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  gpm_cmd_t               cmd,
    input  logic [LEN_W-1:0]       len,
    input  logic [MAX_PATTERN-1:0] star_mask,
    input  logic [MAX_PATTERN-1:0] hit_mask,
    output logic                   matched
);

    localparam int POS_W  = MAX_PATTERN + 1;
    localparam int LEVELS = $clog2(POS_W);
    localparam logic [POS_W-1:0] START_SET = POS_W'(1);

    logic [POS_W-1:0] live_reg;
    logic [POS_W-1:0] live_next;
    logic [POS_W-1:0] closed;
    logic [POS_W-1:0] stepped;

    // A live star also makes the following position live; runs of stars
    // close like a carry chain, so a prefix network does it in LEVELS steps.
    always_comb
    begin
        logic [POS_W-1:0] gen;
        logic [POS_W-1:0] prop;
        gen  = live_reg;
        prop = {star_mask, 1'b0};
        for (int s = 0; s < LEVELS; s++)
        begin
            gen  = gen | (prop & (gen << (1 << s)));
            prop = prop & (prop << (1 << s));
        end
        closed = gen;
    end

    // A star keeps its position live; a matching byte advances by one.
    assign stepped = {1'b0, closed[MAX_PATTERN-1:0] & star_mask}
                   | {closed[MAX_PATTERN-1:0] & hit_mask, 1'b0};

    assign matched = closed[len];

    // Any pattern edit or subject end restarts at position zero.
    always_comb
    begin
        live_next = live_reg;
        if (cmd.clear || cmd.append || cmd.finish)
        begin
            live_next = START_SET;
        end
        else if (cmd.feed)
        begin
            live_next = stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= START_SET;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    `GPM_ASSERT_NEXT(a_restart_after_edit, clk, rst_n, (cmd.clear || cmd.append), (live_reg == START_SET), "live set not restarted after pattern edit")

endmodule

// ----- rtl/glob_pattern_matcher_unit.sv -----
// Top level of the glob pattern matcher: input register, pattern store,
// live-position set and result register. Depends on gpm_pkg, the macros,
// gpm_pattern_store and gpm_live_set.
//
// Usage: the item channel carries transactions of {func, ch}. func clears
// the pattern, appends one pattern byte ('*' any run, '?' any one byte),
// feeds one subject byte, or ends the subject. Only an end-of-subject
// transaction produces a result {matched, pattern_overflow} on the result
// channel; the others only update internal state.
// An accepted item is held in the input register and processed from there.
// Throughput: one item per cycle, except that an end-of-subject item stalls
// while a held result is not taken. The limit is the combinational star
// closure and byte step over all pattern positions, done in parallel.
// Reset empties the pattern, clears the overflow flag and makes only
// position zero live; the pattern bytes themselves are not cleared.
// When the receiver stalls, the result is held in the output register and
// non-result items keep flowing; an end-of-subject item waits in the input
// register until the held result is taken, and item_ready is low meanwhile.
`include "glob_pattern_matcher_unit_macros.svh"

module glob_pattern_matcher_unit
    import gpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  gpm_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output gpm_out_t result
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    gpm_in_t                in_data_reg;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    gpm_out_t               res_reg;
    logic                   finish;
    logic                   advance;
    gpm_cmd_t               cmd;
    logic [LEN_W-1:0]       len;
    logic                   overflow;
    logic [MAX_PATTERN-1:0] star_mask;
    logic [MAX_PATTERN-1:0] hit_mask;
    logic                   matched;

    // Stage control: only a result-producing item waits for output space.
    assign finish     = (in_data_reg.func == FUNC_END);
    assign advance    = in_valid_reg && (!finish || !res_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    // Command decode for the item being processed.
    always_comb
    begin
        cmd = '0;
        if (advance)
        begin
            unique case (in_data_reg.func)
                FUNC_CLEAR:  cmd.clear  = 1'b1;
                FUNC_APPEND: cmd.append = 1'b1;
                FUNC_FEED:   cmd.feed   = 1'b1;
                FUNC_END:    cmd.finish = 1'b1;
                default:     cmd = '0;
            endcase
        end
    end

    // Input register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_data_reg <= item;
        end
    end

    gpm_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ch        (in_data_reg.ch),
        .len       (len),
        .overflow  (overflow),
        .star_mask (star_mask),
        .hit_mask  (hit_mask)
    );

    gpm_live_set #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_live (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .len       (len),
        .star_mask (star_mask),
        .hit_mask  (hit_mask),
        .matched   (matched)
    );

    // Result register.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg.matched          <= matched;
            res_reg.pattern_overflow <= overflow;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `GPM_ASSERT_NEXT(a_finish_gives_result, clk, rst_n, cmd.finish, res_valid_reg, "end of subject produced no result")
    `GPM_ASSERT_IMPL(a_full_stage_drains, clk, rst_n, (item_valid && item_ready && in_valid_reg), advance, "input register overwritten without advancing")
    `GPM_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, (res_valid_reg && !result_ready), !cmd.finish, "held result overwritten")

endmodule
